// File: rtl/b64c_pkg.sv
`timescale 1ns / 1ps

package b64c_pkg;

   localparam int unsigned BundleSlots = 4;

   localparam logic [7:0] CharPad     = 8'h3D;  // '='
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharUpperZ  = 8'h5A;
   localparam logic [7:0] CharLowerA  = 8'h61;
   localparam logic [7:0] CharLowerZ  = 8'h7A;
   localparam logic [7:0] CharDigit0  = 8'h30;
   localparam logic [7:0] CharDigit9  = 8'h39;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharBel     = 8'h07;
   localparam logic [7:0] CharCr      = 8'h0D;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   typedef enum logic [1:0] {
      SYM_DATA  = 2'd0,
      SYM_PAD   = 2'd1,
      SYM_SPACE = 2'd2,
      SYM_BAD   = 2'd3
   } sym_class_type;

   typedef struct packed {
      sym_class_type cls;
      logic [5:0]    val;
   } sym_type;

   // results of one input transaction, slot 0 leaves first
   typedef struct packed {
      logic [BundleSlots-1:0][7:0] data;
      logic [2:0]                  count;
      logic                        last;
      logic                        empty;
      logic                        bad;
   } bundle_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)      return CharUpperA + w;
      else if (v < 6'd52) return CharLowerA + w - 8'd26;
      else if (v < 6'd62) return CharDigit0 + w - 8'd52;
      else if (v == 6'd62) return CharPlus;
      else                return CharSlash;
   endfunction

   function automatic sym_type classify(input logic [7:0] c);
      sym_type    r;
      logic [7:0] s;
      s     = {1'b0, c[6:0]};
      r.val = 6'd0;
      r.cls = SYM_BAD;
      if (c == CharSpace || (c >= CharBel && c <= CharCr)) begin
         r.cls = SYM_SPACE;
      end else if (s >= CharUpperA && s <= CharUpperZ) begin
         r.cls = SYM_DATA;
         r.val = 6'(s - CharUpperA);
      end else if (s >= CharLowerA && s <= CharLowerZ) begin
         r.cls = SYM_DATA;
         r.val = 6'(s - CharLowerA + 8'd26);
      end else if (s >= CharDigit0 && s <= CharDigit9) begin
         r.cls = SYM_DATA;
         r.val = 6'(s - CharDigit0 + 8'd52);
      end else if (s == CharPlus) begin
         r.cls = SYM_DATA;
         r.val = 6'd62;
      end else if (s == CharSlash) begin
         r.cls = SYM_DATA;
         r.val = 6'd63;
      end else if (s == CharPad) begin
         r.cls = SYM_PAD;
      end
      return r;
   endfunction

endpackage

// File: rtl/base64_stream_codec.sv
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// req_     | in        | req_valid/req_ready  | req_in_byte, req_in_last
// rsp_     | out       | rsp_valid/rsp_ready  | rsp_out_byte, rsp_out_empty, rsp_out_last,
//          |           |                      | rsp_bad_char
// csr_     | in        | csr_wr_en            | csr_wr_data (mode)
//
// A transaction is decoded in the cycle it is accepted; its 0 to 4 results are
// loaded into the output buffer and leave one per cycle while rsp_ready is high.
// The next transaction is accepted in the cycle the buffer's final result leaves.
// Synchronous reset clears mode to encode, the group state and the output buffer.

module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_empty,
   output logic       rsp_out_last,
   output logic       rsp_bad_char
);

   b64c_pkg::bundle_type bundle;
   logic push;
   logic accept;
   logic can_take;

   assign req_ready = can_take;
   assign accept    = req_valid && can_take;

   b64c_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .in_last     (req_in_last),
      .push        (push),
      .bundle      (bundle)
   );

   b64c_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .bundle        (bundle),
      .can_take      (can_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_empty (rsp_out_empty),
      .rsp_out_last  (rsp_out_last),
      .rsp_bad_char  (rsp_bad_char)
   );

endmodule

// File: rtl/b64c_core.sv
`timescale 1ns / 1ps

module b64c_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                push,
   output b64c_pkg::bundle_type bundle
);

   logic        mode_ff;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  gcount_ff, gcount_in;
   logic [1:0]  pads_ff, pads_in;
   logic        err_ff, err_in;

   // encode path
   logic [1:0]  enc_n;
   logic [2:0]  enc_n1;
   logic [23:0] enc_bits;
   logic        enc_full;

   // decode path
   b64c_pkg::sym_type sym;
   logic        is_sym;
   logic [23:0] dec_bits;
   logic [1:0]  dec_pads;
   logic [1:0]  dec_gcount;
   logic        dec_full;
   logic [2:0]  nsym;
   logic [2:0]  ndata;
   logic [2:0]  nbytes;
   logic        dec_err;

   always_comb begin
      enc_n = (gcount_ff == 2'd3) ? 2'd2 : gcount_ff;
      case (enc_n)
         2'd0:    enc_bits = bits_ff | {in_byte, 16'h0000};
         2'd1:    enc_bits = bits_ff | {8'h00, in_byte, 8'h00};
         default: enc_bits = bits_ff | {16'h0000, in_byte};
      endcase
      enc_n1   = {1'b0, enc_n} + 3'd1;
      enc_full = (enc_n1 == 3'd3) || in_last;

      sym    = b64c_pkg::classify(in_byte);
      is_sym = (sym.cls == b64c_pkg::SYM_DATA) || (sym.cls == b64c_pkg::SYM_PAD);
      case (gcount_ff)
         2'd0:    dec_bits = bits_ff | {sym.val, 18'h0};
         2'd1:    dec_bits = bits_ff | {6'h0, sym.val, 12'h0};
         2'd2:    dec_bits = bits_ff | {12'h0, sym.val, 6'h0};
         default: dec_bits = bits_ff | {18'h0, sym.val};
      endcase
      if (!is_sym) dec_bits = bits_ff;
      dec_pads = pads_ff;
      if (sym.cls == b64c_pkg::SYM_PAD && pads_ff != 2'd3) dec_pads = pads_ff + 2'd1;
      dec_full   = is_sym && (gcount_ff == 2'd3);
      dec_gcount = is_sym ? gcount_ff + 2'd1 : gcount_ff;
      dec_err    = err_ff || (sym.cls == b64c_pkg::SYM_BAD)
                   || (sym.cls == b64c_pkg::SYM_DATA && pads_ff != 2'd0);
      if (dec_full)     nsym = 3'd4;
      else if (in_last) nsym = {1'b0, dec_gcount};
      else              nsym = 3'd0;
      ndata  = (nsym > {1'b0, dec_pads}) ? nsym - {1'b0, dec_pads} : 3'd0;
      nbytes = (ndata >= 3'd2) ? ndata - 3'd1 : 3'd0;

      bundle    = '0;
      bits_in   = bits_ff;
      gcount_in = gcount_ff;
      pads_in   = pads_ff;
      err_in    = err_ff;
      if (mode_ff == b64c_pkg::ModeEncode) begin
         for (int i = 0; i < b64c_pkg::BundleSlots; i++) begin
            if (3'(i) < enc_n1 + 3'd1)
               bundle.data[i] = b64c_pkg::b64_char(enc_bits[23-6*i -: 6]);
            else
               bundle.data[i] = b64c_pkg::CharPad;
         end
         bundle.count = enc_full ? 3'd4 : 3'd0;
         bundle.last  = in_last;
         if (enc_full) begin
            bits_in   = '0;
            gcount_in = 2'd0;
         end else begin
            bits_in   = enc_bits;
            gcount_in = enc_n1[1:0];
         end
         pads_in = 2'd0;
         err_in  = 1'b0;
      end else begin
         bundle.data[0] = dec_bits[23:16];
         bundle.data[1] = dec_bits[15:8];
         bundle.data[2] = dec_bits[7:0];
         bundle.bad     = dec_err;
         bundle.last    = in_last;
         if (in_last && nbytes == 3'd0) begin
            bundle.count   = 3'd1;
            bundle.empty   = 1'b1;
            bundle.data[0] = 8'h00;
         end else begin
            bundle.count = nbytes;
         end
         if (dec_full || in_last) begin
            bits_in   = '0;
            gcount_in = 2'd0;
            pads_in   = 2'd0;
         end else begin
            bits_in   = dec_bits;
            gcount_in = dec_gcount;
            pads_in   = dec_pads;
         end
         err_in = in_last ? 1'b0 : dec_err;
      end
   end

   assign push = accept && (bundle.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= b64c_pkg::ModeEncode;
         bits_ff   <= '0;
         gcount_ff <= 2'd0;
         pads_ff   <= 2'd0;
         err_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff   <= csr_wr_data;
         bits_ff   <= '0;
         gcount_ff <= 2'd0;
         pads_ff   <= 2'd0;
         err_ff    <= 1'b0;
      end else if (accept) begin
         bits_ff   <= bits_in;
         gcount_ff <= gcount_in;
         pads_ff   <= pads_in;
         err_ff    <= err_in;
      end
   end

endmodule

// File: rtl/b64c_serializer.sv
`timescale 1ns / 1ps

module b64c_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64c_pkg::bundle_type bundle,
   output logic                 can_take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_empty,
   output logic                 rsp_out_last,
   output logic                 rsp_bad_char
);

   logic [b64c_pkg::BundleSlots-1:0][7:0] data_ff;
   logic [2:0] rem_ff;
   logic       last_ff;
   logic       empty_ff;
   logic       bad_ff;
   logic       take;

   assign rsp_valid     = (rem_ff != 3'd0);
   assign take          = rsp_valid && rsp_ready;
   assign can_take      = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ready);
   assign rsp_out_byte  = data_ff[0];
   assign rsp_out_empty = empty_ff;
   assign rsp_out_last  = last_ff && (rem_ff == 3'd1);
   assign rsp_bad_char  = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
      end else if (push) begin
         rem_ff <= bundle.count;
      end else if (take) begin
         rem_ff <= rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff  <= bundle.data;
         last_ff  <= bundle.last;
         empty_ff <= bundle.empty;
         bad_ff   <= bundle.bad;
      end else if (take) begin
         data_ff <= {8'h00, data_ff[b64c_pkg::BundleSlots-1:1]};
      end
   end

endmodule
